FILE: rtl/ooi_pkg.sv
// ----------------------------------------------------------------------------
// ooi_pkg: shared types and constants
// Transaction payloads, register map, cell codes and control bundles for the
// occupancy obstacle inflation block.
// ----------------------------------------------------------------------------
package ooi_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_REACH  = 8;

  localparam logic [7:0] OBSTACLE_CODE = 8'd100;
  localparam logic [7:0] INFLATED_CODE = 8'd70;
  localparam logic [7:0] FREE_CODE     = 8'd0;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_REACH_CELLS = 2'd2,
    REG_RADIUS_SQ   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              func;
    logic [7:0]        col;
    logic [7:0]        row;
    logic signed [7:0] cell_value;
  } req_t;

  typedef struct packed {
    logic signed [7:0] inflated_value;
    logic [7:0]        out_col;
    logic [7:0]        out_row;
  } rsp_t;

  typedef struct packed {
    logic [8:0] grid_width;
    logic [8:0] grid_height;
    logic [3:0] reach_cells;
    logic [7:0] radius_sq_cells;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic centre;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic centre_obst;
    logic reach_zero;
    logic near;
    logic last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/ooi_ctrl.sv
// ----------------------------------------------------------------------------
// ooi_ctrl: query sequencer
// Steps a query through centre lookup, window scan and result hand-off.
// ----------------------------------------------------------------------------
module ooi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_func,
  input  ooi_pkg::stat_t stat,
  output logic           req_ready,
  output ooi_pkg::cmd_t  cmd
);
  import ooi_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_func == FUNC_QUERY) begin
          state_next = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        if (stat.outside || stat.centre_obst || stat.reach_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (stat.near) begin
          state_next = ST_DONE;
        end else if (stat.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && req_valid;
    cmd.centre   = (state == ST_CENTRE);
    cmd.scan     = (state == ST_SCAN);
    cmd.load_out = (state == ST_DONE) && stat.out_free;
  end

endmodule

FILE: rtl/ooi_dp.sv
// ----------------------------------------------------------------------------
// ooi_dp: grid store and window datapath
// Cell memory, window offset counters, distance test, obstacle flag and the
// result register.
// ----------------------------------------------------------------------------
module ooi_dp #(
  parameter int MAX_WIDTH  = ooi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ooi_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_REACH  = ooi_pkg::DEF_MAX_REACH
) (
  input  logic           clk,
  input  logic           rst,
  input  ooi_pkg::cfg_t  cfg,
  input  ooi_pkg::req_t  req,
  input  ooi_pkg::cmd_t  cmd,
  output ooi_pkg::stat_t stat,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output ooi_pkg::rsp_t  rsp
);
  import ooi_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = AW + 10;

  logic [7:0] mem [Depth];

  logic [8:0]        w_eff;
  logic [8:0]        h_eff;
  logic [3:0]        reach_eff;
  logic signed [4:0] reach_s;
  logic signed [4:0] reach_m1;

  logic [7:0]        q_col;
  logic [7:0]        q_row;
  logic              outside;
  logic [7:0]        here;
  logic signed [4:0] dx;
  logic signed [4:0] dy;
  logic              probe;
  logic              near;
  logic [7:0]        rd_data;

  logic signed [9:0] xx;
  logic signed [9:0] yy;
  logic              in_win;
  logic signed [9:0] dx2;
  logic signed [9:0] dy2;
  logic signed [9:0] d2;
  logic              d2_ok;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic              req_inside;
  logic [7:0]        result;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] y);
    logic [PW-1:0] a;
    a = PW'(y) * PW'(MAX_WIDTH) + PW'(x);
    return a[AW-1:0];
  endfunction

  always_comb begin
    w_eff     = (int'(cfg.grid_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.grid_width;
    h_eff     = (int'(cfg.grid_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg.grid_height;
    reach_eff = (int'(cfg.reach_cells) > MAX_REACH) ? 4'(MAX_REACH) : cfg.reach_cells;
    reach_s   = $signed({1'b0, reach_eff});
    reach_m1  = reach_s - 5'sd1;
  end

  always_comb begin
    xx     = $signed({2'b00, q_col}) + $signed({{5{dx[4]}}, dx});
    yy     = $signed({2'b00, q_row}) + $signed({{5{dy[4]}}, dy});
    in_win = !xx[9] && !yy[9] &&
             (xx < $signed({1'b0, w_eff})) && (yy < $signed({1'b0, h_eff}));
    dx2    = dx * dx;
    dy2    = dy * dy;
    d2     = dx2 + dy2;
    d2_ok  = d2 <= $signed({2'b00, cfg.radius_sq_cells});
  end

  always_comb begin
    req_inside = ({1'b0, req.col} < w_eff) && ({1'b0, req.row} < h_eff);
    wr_en      = cmd.accept && (req.func == FUNC_WRITE) &&
                 (int'(req.col) < MAX_WIDTH) && (int'(req.row) < MAX_HEIGHT);
    wr_addr    = cell_addr({1'b0, req.col}, {1'b0, req.row});
    rd_addr    = cmd.scan ? cell_addr(xx[8:0], yy[8:0]) : wr_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= $unsigned(req.cell_value);
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_col   <= req.col;
      q_row   <= req.row;
      outside <= !req_inside;
    end
    if (cmd.centre) begin
      here <= rd_data;
      dx   <= -reach_s;
      dy   <= -reach_s;
    end else if (cmd.scan) begin
      if (dx == reach_m1) begin
        dx <= -reach_s;
        dy <= dy + 5'sd1;
      end else begin
        dx <= dx + 5'sd1;
      end
    end
  end

  // probe marks a read in flight whose cell is in the grid and within radius
  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= 1'b0;
      near  <= 1'b0;
    end else begin
      probe <= cmd.scan && in_win && d2_ok;
      if (cmd.centre) begin
        near <= 1'b0;
      end else if (probe && rd_data == OBSTACLE_CODE) begin
        near <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.outside     = outside;
    stat.centre_obst = (rd_data == OBSTACLE_CODE);
    stat.reach_zero  = (reach_eff == 4'd0);
    stat.near        = near;
    stat.last        = (dx == reach_m1) && (dy == reach_m1);
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  always_comb begin
    priority if (outside) begin
      result = FREE_CODE;
    end else if (here == OBSTACLE_CODE) begin
      result = OBSTACLE_CODE;
    end else if (near) begin
      result = INFLATED_CODE;
    end else begin
      result = here;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.inflated_value <= $signed(result);
      rsp.out_col        <= q_col;
      rsp.out_row        <= q_row;
    end
  end

endmodule

FILE: rtl/occupancy_obstacle_inflation.sv
// ----------------------------------------------------------------------------
// occupancy_obstacle_inflation: obstacle inflation over a stored grid
// Loads an occupancy grid by cell writes; answers cell queries with 100 for an
// obstacle, 70 when an obstacle lies within the set radius, else the stored
// value, and 0 for a cell off the grid.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/ready    | func, col, row, cell_value
//   rsp     | out       | rsp_valid/ready    | inflated_value, out_col, out_row
//   apb     | in        | psel/penable       | four config registers
//
// A query scans a window of (2*reach)^2 cells through the single read port of
// the cell memory (one window cell per cycle); the scan stops early when an
// obstacle turns up, and is skipped when the centre is an obstacle or off-grid.
// Reset clears control only; the cell memory is undefined until written.
// A stalled result is held in the output register while the next transaction
// is taken; a query then waits at its end until the register frees.
// ----------------------------------------------------------------------------
module occupancy_obstacle_inflation #(
  parameter int MAX_WIDTH  = ooi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ooi_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_REACH  = ooi_pkg::DEF_MAX_REACH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ooi_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ooi_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ooi_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width      <= 9'd256;
      cfg.grid_height     <= 9'd256;
      cfg.reach_cells     <= 4'd3;
      cfg.radius_sq_cells <= 8'd4;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  cfg.grid_width      <= pwdata[8:0];
        REG_GRID_HEIGHT: cfg.grid_height     <= pwdata[8:0];
        REG_REACH_CELLS: cfg.reach_cells     <= pwdata[3:0];
        REG_RADIUS_SQ:   cfg.radius_sq_cells <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = {23'd0, cfg.grid_width};
      REG_GRID_HEIGHT: prdata = {23'd0, cfg.grid_height};
      REG_REACH_CELLS: prdata = {28'd0, cfg.reach_cells};
      REG_RADIUS_SQ:   prdata = {24'd0, cfg.radius_sq_cells};
      default:         prdata = 32'd0;
    endcase
  end

  ooi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  ooi_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_REACH  (MAX_REACH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/ooi_checker.sv
// ----------------------------------------------------------------------------
// ooi_checker: port-level checks
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module ooi_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ooi_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ooi_pkg::rsp_t rsp
);
  import ooi_pkg::*;

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a held response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // no transaction produces a result in the following cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("response appeared one cycle after a transaction");

  // a query occupies the block: no new transaction next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.func == FUNC_QUERY |=> !req_ready)
    else $error("request taken while a query is in progress");

endmodule

bind occupancy_obstacle_inflation ooi_checker u_ooi_checker (.*);
